FILE: sv/dlc_pkg.sv
// Shared types and constants for the door lock controller.
package dlc_pkg;

    localparam int unsigned ELAPSED_W  = 8;
    localparam int unsigned COUNTER_W  = 16;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [COUNTER_W-1:0] AUTO_LOCK_RESET = 16'd10000;
    localparam logic [COUNTER_W-1:0] COUNTER_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_LOCKED = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_OPEN   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        EVT_NONE           = 3'd0,
        EVT_UNLOCKED       = 3'd1,
        EVT_OPENED         = 3'd2,
        EVT_CLOSED_LOCKED  = 3'd3,
        EVT_TIMEOUT_LOCKED = 3'd4
    } t_event;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 door_level;
        logic                 sensor_edge;
        logic                 unlock_req;
    } t_pass;

    typedef struct packed {
        t_event second_event;
        t_event first_event;
        t_mode  door_mode;
        logic   lock_engaged;
    } t_result;

endpackage

FILE: sv/door_lock_controller_top.sv
// Door lock controller: one poll pass in, one status beat out.
//
//  channel   dir  handshake                     payload (lowest bit up)
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  unlock_req, sensor_edge,
//                                                door_level, elapsed_ms[7:0]
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  lock_engaged, door_mode[1:0],
//                                                first_event[2:0], second_event[2:0]
//  cfg       in   i_cfg_wen                     auto_lock_ms[15:0]
//
// A pass is taken into an input register, evaluated by combinational logic
// and lands in the result register; one pass is accepted per cycle while
// the output is not stalled. Controller state updates when the pass moves
// into the result register.
// Synchronous active-low reset: locked, door closed, counter zero,
// auto_lock_ms 10000, both stages empty.
// A stalled output holds its beat; the input register still takes one more
// beat, after which s_axis backs up.
module door_lock_controller_top
    import dlc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [0] unlock_req, [1] sensor_edge, [2] door_level, [10:3] elapsed_ms, rest zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] lock_engaged, [2:1] door_mode, [5:3] first_event, [8:6] second_event,
    // rest zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_wen,
    input  logic [COUNTER_W-1:0]  i_cfg_wdata
);

    localparam int unsigned PASS_W = $bits(t_pass);
    localparam int unsigned RES_W  = $bits(t_result);

    // Pipeline registers
    logic                 r_in_valid;
    t_pass                r_in;
    logic                 r_out_valid;
    t_result              r_out;

    // Controller state
    t_mode                r_mode,    n_mode;
    logic                 r_open,    n_open;
    logic                 r_pending, n_pending;
    logic [COUNTER_W-1:0] r_count,   n_count;
    logic [COUNTER_W-1:0] r_auto_lock;

    t_result              n_out;
    logic                 out_free;
    logic                 advance;
    logic [COUNTER_W:0]   sum;

    // Result register can load when empty or draining this cycle.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || advance;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, r_out};

    // Evaluate one pass in order: count, unlock, sensor, timeout.
    always_comb begin
        t_event ev1;
        t_event ev2;
        ev1 = EVT_NONE;
        ev2 = EVT_NONE;

        // Saturating wait counter
        sum = {1'b0, r_count} + {{(COUNTER_W+1-ELAPSED_W){1'b0}}, r_in.elapsed_ms};
        n_count = sum[COUNTER_W] ? COUNTER_MAX : sum[COUNTER_W-1:0];
        n_mode    = r_mode;
        n_open    = r_open;
        n_pending = r_pending | r_in.sensor_edge;

        if (r_in.unlock_req && r_mode == MODE_LOCKED) begin
            n_count = '0;
            n_mode  = MODE_WAIT;
            ev1     = EVT_UNLOCKED;
        end

        // Edge seen while locked stays pending.
        if (n_pending && n_mode != MODE_LOCKED) begin
            n_pending = 1'b0;
            if (r_in.door_level != r_open) begin
                if (r_in.door_level) begin
                    n_mode = MODE_OPEN;
                    if (ev1 == EVT_NONE) ev1 = EVT_OPENED;
                    else                 ev2 = EVT_OPENED;
                end else begin
                    n_mode = MODE_LOCKED;
                    if (ev1 == EVT_NONE) ev1 = EVT_CLOSED_LOCKED;
                    else                 ev2 = EVT_CLOSED_LOCKED;
                end
            end
            n_open = r_in.door_level;
        end

        // Auto-lock while still waiting for the door to open
        if (n_mode == MODE_WAIT && n_count >= r_auto_lock) begin
            n_mode = MODE_LOCKED;
            if (ev1 == EVT_NONE) ev1 = EVT_TIMEOUT_LOCKED;
            else                 ev2 = EVT_TIMEOUT_LOCKED;
        end

        n_out.lock_engaged = (n_mode == MODE_LOCKED);
        n_out.door_mode    = n_mode;
        n_out.first_event  = ev1;
        n_out.second_event = ev2;
    end

    // Handshake and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_LOCKED;
            r_open      <= 1'b0;
            r_pending   <= 1'b0;
            r_count     <= '0;
            r_auto_lock <= AUTO_LOCK_RESET;
        end else begin
            if (i_cfg_wen) begin
                r_auto_lock <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            // Commit controller state as the pass moves on
            if (advance) begin
                r_mode    <= n_mode;
                r_open    <= n_open;
                r_pending <= n_pending;
                r_count   <= n_count;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= t_pass'(i_s_axis_tdata[PASS_W-1:0]);
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: sv/dlc_checker.sv
// Port-level checks for the door lock controller, bound to the top level.
module dlc_checker
    import dlc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  o_s_axis_tready,
    input  logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_result res;
    assign res = t_result'(o_m_axis_tdata[$bits(t_result)-1:0]);

    // Hold a stalled result beat.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result beat changed while stalled");

    // Drop any result after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Bolt flag tracks the reported mode.
    a_bolt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (res.lock_engaged == (res.door_mode == MODE_LOCKED)))
        else $error("lock_engaged disagrees with door_mode");

    // Fill the first event slot before the second.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && res.second_event != EVT_NONE) |-> (res.first_event != EVT_NONE))
        else $error("second event without first");

    // A pass accepted while the result register is empty is followed by a valid result beat.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid && i_m_axis_tready)
        |=> ##1 o_m_axis_tvalid)
        else $error("result missing two cycles after accept");

endmodule

bind door_lock_controller_top dlc_checker u_dlc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
